@@ rtl/arc_bounding_box_unit_assert.svh @@
// Assertion macros used by the checker of the arc bounding box unit.
`ifndef ARC_BOUNDING_BOX_UNIT_ASSERT_SVH
`define ARC_BOUNDING_BOX_UNIT_ASSERT_SVH

// Both macros expect clk and rst_n in the scope where they are used.
`define ARC_BB_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("arc bounding box unit: check failed");

`define ARC_BB_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("arc bounding box unit: check failed");

`endif

@@ rtl/arc_bb_pkg.sv @@
// Package with the widths, types and helpers of the arc bounding box unit.
package arc_bb_pkg;

    localparam int CW = 32;
    localparam int D_W = CW + 1;
    localparam int P_W = 2 * D_W;
    localparam int RT_W = D_W;
    localparam int SQ_W = 2 * RT_W;
    localparam int OUT_W = 34;
    localparam int EXT_W = (CW + 3 > OUT_W) ? CW + 3 : OUT_W;
    localparam int IN_DATA_W = ((6 * CW + 7) / 8) * 8;
    localparam int IN_USER_W = 1;
    localparam int OUT_DATA_W = ((4 * OUT_W + 7) / 8) * 8;
    // Register stages from the input to the last box stage.
    localparam int PIPE_DEPTH = RT_W + 4;

    localparam logic signed [EXT_W-1:0] OUT_MAX_E = (EXT_W'(1) << (OUT_W - 1)) - EXT_W'(1);
    localparam logic signed [EXT_W-1:0] OUT_MIN_E = ~OUT_MAX_E;
    localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_MAX_E[OUT_W-1:0];
    localparam logic signed [OUT_W-1:0] OUT_MIN = OUT_MIN_E[OUT_W-1:0];

    typedef struct packed {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic                 ccw;
    } arc_t;

    // Everything that rides alongside the square root pipeline.
    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] left;
        logic signed [CW-1:0] right;
        logic signed [CW-1:0] bottom;
        logic signed [CW-1:0] top;
        logic                 cross_right;
        logic                 cross_top;
        logic                 cross_left;
        logic                 cross_bottom;
    } side_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] top;
        logic signed [OUT_W-1:0] bottom;
        logic signed [OUT_W-1:0] right;
        logic signed [OUT_W-1:0] left;
    } box_t;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [EXT_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > OUT_MAX_E)
        begin
            r = OUT_MAX;
        end
        else if (v < OUT_MIN_E)
        begin
            r = OUT_MIN;
        end
        else
        begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/arc_bb_front.sv @@
// Front end: endpoint vectors, squares, cross products and direction crossing flags.
module arc_bb_front
    import arc_bb_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  arc_t            in_arc,
    output logic            out_valid,
    output logic [SQ_W-1:0] out_sq,
    output side_t           out_side
);

    function automatic logic lower_half(input logic signed [D_W-1:0] x,
                                        input logic signed [D_W-1:0] y);
        logic upper;
        upper = (y > 0) || ((y == 0) && (x >= 0));
        return !upper;
    endfunction

    // Stage 1: vectors from the centre.
    logic                  s1_valid_reg;
    logic signed [D_W-1:0] vs_x_reg, vs_y_reg, ve_x_reg, ve_y_reg;
    arc_t                  s1_arc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vs_x_reg   <= D_W'(in_arc.sx) - D_W'(in_arc.cx);
            vs_y_reg   <= D_W'(in_arc.sy) - D_W'(in_arc.cy);
            ve_x_reg   <= D_W'(in_arc.ex) - D_W'(in_arc.cx);
            ve_y_reg   <= D_W'(in_arc.ey) - D_W'(in_arc.cy);
            s1_arc_reg <= in_arc;
        end
    end

    // Stage 2: a zero vector points along +x; a clockwise arc swaps its ends.
    logic signed [D_W-1:0] s_fx, e_fx, a_x, a_y, b_x, b_y;
    logic                  a_low, b_low;

    assign s_fx  = (vs_x_reg == 0 && vs_y_reg == 0) ? D_W'(1) : vs_x_reg;
    assign e_fx  = (ve_x_reg == 0 && ve_y_reg == 0) ? D_W'(1) : ve_x_reg;
    assign a_x   = s1_arc_reg.ccw ? s_fx : e_fx;
    assign a_y   = s1_arc_reg.ccw ? vs_y_reg : ve_y_reg;
    assign b_x   = s1_arc_reg.ccw ? e_fx : s_fx;
    assign b_y   = s1_arc_reg.ccw ? ve_y_reg : vs_y_reg;
    assign a_low = lower_half(a_x, a_y);
    assign b_low = lower_half(b_x, b_y);

    logic                  s2_valid_reg;
    logic signed [P_W-1:0] sq_x_reg, sq_y_reg, cr_ba_reg, cr_ab_reg;
    logic                  a_low_reg, b_low_reg;
    logic                  top_s_reg, top_e_reg, left_s_reg, left_e_reg, bot_s_reg, bot_e_reg;
    side_t                 s2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_x_reg  <= vs_x_reg * vs_x_reg;
            sq_y_reg  <= vs_y_reg * vs_y_reg;
            cr_ba_reg <= b_x * a_y;
            cr_ab_reg <= b_y * a_x;
            a_low_reg <= a_low;
            b_low_reg <= b_low;
            top_s_reg  <= !a_low && (a_x > 0);
            top_e_reg  <= b_low || (b_x < 0);
            left_s_reg <= !a_low;
            left_e_reg <= b_y < 0;
            bot_s_reg  <= !a_low || (a_x < 0);
            bot_e_reg  <= b_low && (b_x > 0);
            s2_side_reg.cx     <= s1_arc_reg.cx;
            s2_side_reg.cy     <= s1_arc_reg.cy;
            s2_side_reg.left   <= (s1_arc_reg.sx < s1_arc_reg.ex) ? s1_arc_reg.sx : s1_arc_reg.ex;
            s2_side_reg.right  <= (s1_arc_reg.sx > s1_arc_reg.ex) ? s1_arc_reg.sx : s1_arc_reg.ex;
            s2_side_reg.bottom <= (s1_arc_reg.sy < s1_arc_reg.ey) ? s1_arc_reg.sy : s1_arc_reg.ey;
            s2_side_reg.top    <= (s1_arc_reg.sy > s1_arc_reg.ey) ? s1_arc_reg.sy : s1_arc_reg.ey;
            s2_side_reg.cross_right  <= 1'b0;
            s2_side_reg.cross_top    <= 1'b0;
            s2_side_reg.cross_left   <= 1'b0;
            s2_side_reg.cross_bottom <= 1'b0;
        end
    end

    // Stage 3: the arc wraps through +x when its end lies at a smaller angle than its start.
    logic wrap;

    assign wrap = (a_low_reg != b_low_reg) ? (!b_low_reg && a_low_reg) : (cr_ba_reg > cr_ab_reg);

    logic            s3_valid_reg;
    logic [SQ_W-1:0] s3_sq_reg;
    side_t           s3_side_reg;
    side_t           s3_side_next;

    always_comb
    begin
        s3_side_next              = s2_side_reg;
        s3_side_next.cross_right  = wrap;
        s3_side_next.cross_top    = (top_s_reg && top_e_reg) || (top_s_reg && wrap)
                                    || (top_e_reg && wrap);
        s3_side_next.cross_left   = (left_s_reg && left_e_reg) || (left_s_reg && wrap)
                                    || (left_e_reg && wrap);
        s3_side_next.cross_bottom = (bot_s_reg && bot_e_reg) || (bot_s_reg && wrap)
                                    || (bot_e_reg && wrap);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_sq_reg   <= $unsigned(sq_x_reg) + $unsigned(sq_y_reg);
            s3_side_reg <= s3_side_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_sq    = s3_sq_reg;
    assign out_side  = s3_side_reg;

endmodule

@@ rtl/arc_bb_sqrt.sv @@
// Pipelined floor square root, one root bit per stage, carrying the side data along.
module arc_bb_sqrt
    import arc_bb_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [SQ_W-1:0] in_sq,
    input  side_t           in_side,
    output logic            out_valid,
    output logic [RT_W-1:0] out_root,
    output side_t           out_side
);

    localparam int REM_W = RT_W + 1;

    logic             valid_reg [RT_W];
    logic [REM_W-1:0] rem_reg   [RT_W];
    logic [RT_W-1:0]  root_reg  [RT_W];
    logic [SQ_W-1:0]  rad_reg   [RT_W];
    side_t            side_reg  [RT_W];

    logic             valid_prev [RT_W];
    logic [REM_W-1:0] rem_prev   [RT_W];
    logic [RT_W-1:0]  root_prev  [RT_W];
    logic [SQ_W-1:0]  rad_prev   [RT_W];
    side_t            side_prev  [RT_W];

    for (genvar k = 0; k < RT_W; k++)
    begin : g_stage
        logic [REM_W+1:0] shifted, trial, diff;
        logic             take;
        logic [REM_W-1:0] rem_next;
        logic [RT_W-1:0]  root_next;

        if (k == 0)
        begin : g_head
            assign valid_prev[k] = in_valid;
            assign rem_prev[k]   = '0;
            assign root_prev[k]  = '0;
            assign rad_prev[k]   = in_sq;
            assign side_prev[k]  = in_side;
        end
        else
        begin : g_body
            assign valid_prev[k] = valid_reg[k-1];
            assign rem_prev[k]   = rem_reg[k-1];
            assign root_prev[k]  = root_reg[k-1];
            assign rad_prev[k]   = rad_reg[k-1];
            assign side_prev[k]  = side_reg[k-1];
        end

        // Bring down the next two radicand bits and try the next root bit as a one.
        assign shifted   = {rem_prev[k], rad_prev[k][SQ_W-1-2*k -: 2]};
        assign trial     = {1'b0, root_prev[k], 2'b01};
        assign diff      = shifted - trial;
        assign take      = shifted >= trial;
        assign rem_next  = take ? diff[REM_W-1:0] : shifted[REM_W-1:0];
        assign root_next = {root_prev[k][RT_W-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_prev[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= rad_prev[k];
                side_reg[k] <= side_prev[k];
            end
        end
    end

    assign out_valid = valid_reg[RT_W-1];
    assign out_root  = root_reg[RT_W-1];
    assign out_side  = side_reg[RT_W-1];

endmodule

@@ rtl/arc_bb_outbuf.sv @@
// Output register with a skid entry, so the pipeline keeps moving while a result waits, until the skid entry fills.
module arc_bb_outbuf
    import arc_bb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  box_t in_box,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output box_t out_box
);

    logic out_valid_reg, skid_valid_reg;
    box_t out_box_reg, skid_box_reg;
    logic out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_box_reg <= skid_valid_reg ? skid_box_reg : in_box;
        end
        else if (!skid_valid_reg)
        begin
            skid_box_reg <= in_box;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_box   = out_box_reg;

endmodule

@@ rtl/arc_bounding_box_unit.sv @@
// Top level of the arc bounding box unit: stream ports, box stage and output buffer.
//
// One circular arc goes in per item and its axis-aligned bounding box comes out, one item
// per cycle sustained while m_tready holds. The first register is loaded at the edge that
// accepts an item: three front stages build the vectors, squares and crossing flags, the
// 33-stage square root pipeline resolves one radius bit per stage, one stage widens the
// box and one output register holds it. A skid entry behind the output register lets one
// further item be accepted while a result waits.
module arc_bounding_box_unit
    import arc_bb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // start_x, start_y, end_x, end_y, center_x, center_y
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // counter_clockwise
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // box_left, box_right, box_bottom, box_top
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic            en;
    arc_t            arc;
    logic            fe_valid;
    logic [SQ_W-1:0] fe_sq;
    side_t           fe_side;
    logic            rt_valid;
    logic [RT_W-1:0] rt_root;
    side_t           rt_side;
    box_t            m_box;

    assign s_tready = en;

    assign arc.sx  = s_tdata[0*CW +: CW];
    assign arc.sy  = s_tdata[1*CW +: CW];
    assign arc.ex  = s_tdata[2*CW +: CW];
    assign arc.ey  = s_tdata[3*CW +: CW];
    assign arc.cx  = s_tdata[4*CW +: CW];
    assign arc.cy  = s_tdata[5*CW +: CW];
    assign arc.ccw = s_tuser[0];

    arc_bb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_arc    (arc),
        .out_valid (fe_valid),
        .out_sq    (fe_sq),
        .out_side  (fe_side)
    );

    arc_bb_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fe_valid),
        .in_sq     (fe_sq),
        .in_side   (fe_side),
        .out_valid (rt_valid),
        .out_root  (rt_root),
        .out_side  (rt_side)
    );

    // Box stage: a crossed axis direction pushes its side out to the circle.
    logic signed [EXT_W-1:0] r_e, cx_e, cy_e, xp, xm, yp, ym;
    logic signed [EXT_W-1:0] left_e, right_e, bottom_e, top_e;
    logic signed [EXT_W-1:0] left_v, right_v, bottom_v, top_v;

    assign r_e      = EXT_W'(rt_root);
    assign cx_e     = EXT_W'(rt_side.cx);
    assign cy_e     = EXT_W'(rt_side.cy);
    assign left_e   = EXT_W'(rt_side.left);
    assign right_e  = EXT_W'(rt_side.right);
    assign bottom_e = EXT_W'(rt_side.bottom);
    assign top_e    = EXT_W'(rt_side.top);
    assign xp       = cx_e + r_e;
    assign xm       = cx_e - r_e;
    assign yp       = cy_e + r_e;
    assign ym       = cy_e - r_e;

    assign right_v  = (rt_side.cross_right && (xp > right_e)) ? xp : right_e;
    assign left_v   = (rt_side.cross_left && (xm < left_e)) ? xm : left_e;
    assign top_v    = (rt_side.cross_top && (yp > top_e)) ? yp : top_e;
    assign bottom_v = (rt_side.cross_bottom && (ym < bottom_e)) ? ym : bottom_e;

    logic fin_valid_reg;
    box_t fin_box_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fin_valid_reg <= rt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_box_reg.left   <= sat_out(left_v);
            fin_box_reg.right  <= sat_out(right_v);
            fin_box_reg.bottom <= sat_out(bottom_v);
            fin_box_reg.top    <= sat_out(top_v);
        end
    end

    arc_bb_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fin_valid_reg),
        .in_box    (fin_box_reg),
        .in_ready  (en),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_box   (m_box)
    );

    assign m_tdata = OUT_DATA_W'({m_box.top, m_box.bottom, m_box.right, m_box.left});

endmodule

@@ rtl/arc_bb_checker.sv @@
// Port-level checker of the arc bounding box unit and its bind statement.
`include "arc_bounding_box_unit_assert.svh"

module arc_bb_checker
    import arc_bb_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int INFLIGHT_W = $clog2(PIPE_DEPTH + 3);

    logic                    in_acc, out_acc;
    logic [INFLIGHT_W-1:0]   inflight_reg, inflight_next;
    logic signed [OUT_W-1:0] left_w, right_w, bottom_w, top_w;

    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;
    assign left_w   = m_tdata[0*OUT_W +: OUT_W];
    assign right_w  = m_tdata[1*OUT_W +: OUT_W];
    assign bottom_w = m_tdata[2*OUT_W +: OUT_W];
    assign top_w    = m_tdata[3*OUT_W +: OUT_W];

    always_comb
    begin
        case ({in_acc, out_acc})
            2'b10:   inflight_next = inflight_reg + INFLIGHT_W'(1);
            2'b01:   inflight_next = inflight_reg - INFLIGHT_W'(1);
            default: inflight_next = inflight_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A held result keeps its value until it is taken.
    `ARC_BB_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // The box is never inverted, saturated or not.
    `ARC_BB_ASSERT_IMP(a_box_order, m_tvalid, (left_w <= right_w) && (bottom_w <= top_w))

    // No result shows without an item in flight.
    `ARC_BB_ASSERT_IMP(a_no_phantom, m_tvalid, inflight_reg != '0)

    // The input only stalls once a result has been left waiting at the output.
    `ARC_BB_ASSERT_IMP(a_stall_cause, !s_tready, $past(m_tvalid && !m_tready))

endmodule

bind arc_bounding_box_unit arc_bb_checker u_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for the arc bounding box unit, with its own box predictor.
`timescale 1ns / 100ps

module testbench;
    import arc_bb_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic                 ccw;
    } arc_item_t;

    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW - 1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW - 1){1'b0}}};
    localparam logic signed [CW-1:0] UNIT = 65536;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // start_x, start_y, end_x, end_y, center_x, center_y
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    // counter_clockwise
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // box_left, box_right, box_bottom, box_top
    logic [OUT_DATA_W-1:0] m_tdata;

    box_t pending_boxes[$];
    int   fail_count = 0;

    // Sender and receiver idling controls, changed by the test tasks.
    bit tx_gaps_on = 1'b0;
    int burst_left = 0;
    bit rx_stalls_on = 1'b0;
    int hold_request = 0;

    arc_bounding_box_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    // Upper half-plane (angles in [0, pi)) is 0, the lower one is 1.
    function automatic bit lower_half(input longint x, input longint y);
        return !(y > 0 || (y == 0 && x >= 0));
    endfunction

    // True when the angle of a is strictly below the angle of b, both in [0, 2*pi).
    function automatic bit angle_below(input longint ax, input longint ay,
                                       input longint bx, input longint by);
        bit    ha;
        bit    hb;
        wide_t lhs;
        wide_t rhs;
        ha = lower_half(ax, ay);
        hb = lower_half(bx, by);
        if (ha != hb)
        begin
            return !ha && hb;
        end
        lhs = wide_t'(ax) * wide_t'(by);
        rhs = wide_t'(ay) * wide_t'(bx);
        return lhs > rhs;
    endfunction

    function automatic bit crosses(input longint sx, input longint sy, input longint ex,
                                   input longint ey, input longint tx, input longint ty);
        bit s_lt;
        bit e_gt;
        bit wrap;
        s_lt = angle_below(sx, sy, tx, ty);
        e_gt = angle_below(tx, ty, ex, ey);
        wrap = angle_below(ex, ey, sx, sy);
        return (s_lt && e_gt) || (s_lt && wrap) || (e_gt && wrap);
    endfunction

    function automatic longint floor_sqrt(input wide_t sq);
        wide_t root;
        wide_t cand;
        root = 0;
        for (int b = CW + 1; b >= 0; b--)
        begin
            cand = root | (wide_t'(1) <<< b);
            if (cand * cand <= sq)
            begin
                root = cand;
            end
        end
        return longint'(root);
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp_out(input longint v);
        longint hi_lim;
        longint lo_lim;
        hi_lim = (longint'(1) <<< (OUT_W - 1)) - 1;
        lo_lim = -hi_lim - 1;
        if (v > hi_lim)
        begin
            v = hi_lim;
        end
        if (v < lo_lim)
        begin
            v = lo_lim;
        end
        return v[OUT_W-1:0];
    endfunction

    function automatic box_t predict_arc_box(input arc_item_t a);
        longint sx, sy, ex, ey, cx, cy;
        longint vsx, vsy, vex, vey, tmp, radius;
        longint left, right, bottom, top;
        box_t   b;
        sx = a.sx;
        sy = a.sy;
        ex = a.ex;
        ey = a.ey;
        cx = a.cx;
        cy = a.cy;
        vsx = sx - cx;
        vsy = sy - cy;
        vex = ex - cx;
        vey = ey - cy;
        radius = floor_sqrt(wide_t'(vsx) * wide_t'(vsx) + wide_t'(vsy) * wide_t'(vsy));
        // A point sitting on the centre counts as lying along +x.
        if (vsx == 0 && vsy == 0)
        begin
            vsx = 1;
        end
        if (vex == 0 && vey == 0)
        begin
            vex = 1;
        end
        if (!a.ccw)
        begin
            tmp = vsx; vsx = vex; vex = tmp;
            tmp = vsy; vsy = vey; vey = tmp;
        end
        left = (sx < ex) ? sx : ex;
        right = (sx > ex) ? sx : ex;
        bottom = (sy < ey) ? sy : ey;
        top = (sy > ey) ? sy : ey;
        if (angle_below(vex, vey, vsx, vsy) && cx + radius > right)
        begin
            right = cx + radius;
        end
        if (crosses(vsx, vsy, vex, vey, 0, 1) && cy + radius > top)
        begin
            top = cy + radius;
        end
        if (crosses(vsx, vsy, vex, vey, -1, 0) && cx - radius < left)
        begin
            left = cx - radius;
        end
        if (crosses(vsx, vsy, vex, vey, 0, -1) && cy - radius < bottom)
        begin
            bottom = cy - radius;
        end
        b.left = clamp_out(left);
        b.right = clamp_out(right);
        b.bottom = clamp_out(bottom);
        b.top = clamp_out(top);
        return b;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic arc_item_t make_arc(input logic signed [CW-1:0] sx,
                                           input logic signed [CW-1:0] sy,
                                           input logic signed [CW-1:0] ex,
                                           input logic signed [CW-1:0] ey,
                                           input logic signed [CW-1:0] cx,
                                           input logic signed [CW-1:0] cy,
                                           input logic ccw);
        arc_item_t a;
        a.sx = sx;
        a.sy = sy;
        a.ex = ex;
        a.ey = ey;
        a.cx = cx;
        a.cy = cy;
        a.ccw = ccw;
        return a;
    endfunction

    function automatic logic signed [CW-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return C_MAX;
            1: return C_MIN;
            2: return 0;
            3: return -1;
            4: return 1;
            default: return C_MIN + 1;
        endcase
    endfunction

    // Mostly proper arcs on a circle, with raw noise, exact axis points and tiny
    // coordinates mixed in to reach the ties and zero vectors.
    function automatic arc_item_t random_arc();
        arc_item_t a;
        int        kind;
        int        rad;
        int        rad_e;
        int        k;
        int        ds;
        int        de;
        real       ang_s;
        real       ang_e;
        kind = $urandom_range(0, 99);
        a.ccw = 1'($urandom_range(0, 1));
        a.cx = int'($urandom) >>> 1;
        a.cy = int'($urandom) >>> 1;
        k = $urandom_range(0, 30);
        rad = $urandom_range(0, (1 << k) - 1);
        if (kind < 30)
        begin
            a.sx = $urandom;
            a.sy = $urandom;
            a.ex = $urandom;
            a.ey = $urandom;
            a.cx = $urandom;
            a.cy = $urandom;
        end
        else if (kind < 70)
        begin
            ang_s = $urandom_range(0, 62831) / 10000.0;
            ang_e = ($urandom_range(0, 15) == 0) ? ang_s : $urandom_range(0, 62831) / 10000.0;
            rad_e = ($urandom_range(0, 7) == 0) ? $urandom_range(0, rad) : rad;
            a.sx = a.cx + $rtoi(rad * $cos(ang_s));
            a.sy = a.cy + $rtoi(rad * $sin(ang_s));
            a.ex = a.cx + $rtoi(rad_e * $cos(ang_e));
            a.ey = a.cy + $rtoi(rad_e * $sin(ang_e));
        end
        else if (kind < 85)
        begin
            // Endpoints exactly on the axes or the diagonals through the centre.
            ds = $urandom_range(0, 7);
            de = $urandom_range(0, 7);
            a.sx = a.cx + ((ds inside {0, 1, 7}) ? rad : (ds inside {3, 4, 5}) ? -rad : 0);
            a.sy = a.cy + ((ds inside {1, 2, 3}) ? rad : (ds inside {5, 6, 7}) ? -rad : 0);
            a.ex = a.cx + ((de inside {0, 1, 7}) ? rad : (de inside {3, 4, 5}) ? -rad : 0);
            a.ey = a.cy + ((de inside {1, 2, 3}) ? rad : (de inside {5, 6, 7}) ? -rad : 0);
        end
        else if (kind < 95)
        begin
            a.sx = int'($urandom_range(0, 16)) - 8;
            a.sy = int'($urandom_range(0, 16)) - 8;
            a.ex = int'($urandom_range(0, 16)) - 8;
            a.ey = int'($urandom_range(0, 16)) - 8;
            a.cx = int'($urandom_range(0, 4)) - 2;
            a.cy = int'($urandom_range(0, 4)) - 2;
        end
        else
        begin
            a.sx = pick_extreme();
            a.sy = pick_extreme();
            a.ex = pick_extreme();
            a.ey = pick_extreme();
            a.cx = pick_extreme();
            a.cy = pick_extreme();
        end
        return a;
    endfunction

    // Offers one arc, records its box once it is taken, then maybe pauses.
    task automatic send_arc(input arc_item_t a);
        int gap;
        s_tdata <= IN_DATA_W'({a.cy, a.cx, a.ey, a.ex, a.sy, a.sx});
        s_tuser <= IN_USER_W'(a.ccw);
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        pending_boxes.push_back(predict_arc_box(a));
        if (tx_gaps_on)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 6);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    task automatic test_directed_arcs();
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        // Quarter circle from +x to +y, then the same points the other way round.
        send_arc(make_arc(UNIT, 0, 0, UNIT, 0, 0, 1'b1));
        send_arc(make_arc(UNIT, 0, 0, UNIT, 0, 0, 1'b0));
        // Half circles ending exactly on an axis direction, and the wrap through +x.
        send_arc(make_arc(UNIT, 0, -UNIT, 0, 0, 0, 1'b1));
        send_arc(make_arc(0, -UNIT, 0, UNIT, 0, 0, 1'b1));
        send_arc(make_arc(0, -UNIT, 0, UNIT, 0, 0, 1'b0));
        // Start and end at the same angle: nothing crossed.
        send_arc(make_arc(3 * UNIT, 4 * UNIT, 3 * UNIT, 4 * UNIT, 0, 0, 1'b1));
        send_arc(make_arc(-UNIT, -UNIT, -UNIT, -UNIT, 0, 0, 1'b0));
        // Start or end on the centre itself.
        send_arc(make_arc(5, 7, -3 * UNIT, 7, 5, 7, 1'b1));
        send_arc(make_arc(UNIT, -UNIT, 0, 0, 0, 0, 1'b0));
        send_arc(make_arc(9, 9, 9, 9, 9, 9, 1'b1));
        // End far off the circle; the radius follows the start point.
        send_arc(make_arc(UNIT, 0, -40 * UNIT, -2, 0, 0, 1'b1));
        // Field extremes, with the largest radii both ways round.
        send_arc(make_arc(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1));
        send_arc(make_arc(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b0));
        send_arc(make_arc(C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, 1'b1));
        send_arc(make_arc(C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, 1'b0));
        send_arc(make_arc(C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, 1'b1));
        send_arc(make_arc(C_MIN, 0, C_MAX, 0, 0, 0, 1'b0));
        send_arc(make_arc(0, 0, 0, 0, 0, 0, 1'b0));
        send_arc(make_arc(-1, -1, -1, -1, -1, -1, 1'b1));
    endtask

    task automatic test_random_arcs(input int count, input bit gaps, input bit stalls);
        tx_gaps_on = gaps;
        rx_stalls_on = stalls;
        repeat (count)
        begin
            send_arc(random_arc());
        end
    endtask

    // The receiver holds off long enough for the pipeline and skid entry to fill,
    // so the input side must stall while items keep being offered.
    task automatic test_output_backpressure();
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        hold_request = 300;
        repeat (120)
        begin
            send_arc(random_arc());
        end
    endtask

    // ---------------------------------------------------------------- receiver

    initial
    begin
        int  hold_left;
        int  run_left;
        bit  ready_phase;
        hold_left = 0;
        run_left = 0;
        ready_phase = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!rx_stalls_on)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    ready_phase = !ready_phase;
                    run_left = ready_phase ? $urandom_range(1, 12) : $urandom_range(1, 5);
                end
                run_left--;
                m_tready <= ready_phase;
            end
        end
    end

    always @(posedge clk)
    begin
        box_t got;
        box_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = box_t'(m_tdata[$bits(box_t)-1:0]);
            if (pending_boxes.size() == 0)
            begin
                $error("m_tdata: box received with none expected");
                fail_count++;
            end
            else
            begin
                want = pending_boxes.pop_front();
                if (got.left !== want.left)
                begin
                    $error("box_left: expected %0d, got %0d", want.left, got.left);
                    fail_count++;
                end
                if (got.right !== want.right)
                begin
                    $error("box_right: expected %0d, got %0d", want.right, got.right);
                    fail_count++;
                end
                if (got.bottom !== want.bottom)
                begin
                    $error("box_bottom: expected %0d, got %0d", want.bottom, got.bottom);
                    fail_count++;
                end
                if (got.top !== want.top)
                begin
                    $error("box_top: expected %0d, got %0d", want.top, got.top);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed_arcs();
        test_random_arcs(250, 1'b0, 1'b0);
        test_random_arcs(250, 1'b1, 1'b0);
        test_random_arcs(250, 1'b0, 1'b1);
        test_output_backpressure();
        test_random_arcs(250, 1'b1, 1'b1);
        s_tvalid <= 1'b0;

        while (pending_boxes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DEPTH + 20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
